// File: design/ncv_pkg.sv
// shared types and constants for the normalized convolution core
`timescale 1ns / 1ps
`default_nettype none
package ncv_pkg;
	localparam int WIDTH_BITS  = 12;
	localparam int ROW_BITS    = 16;
	localparam int COL_BITS    = 11;
	localparam int OUT_BITS    = 25;
	localparam int CFG_W       = 60;
	localparam int IDX_W       = 3;
	localparam int IN_DATA_W   = 8;
	localparam int OUT_DATA_W  = 56;
	localparam int OUT_PAD     = OUT_DATA_W - OUT_BITS - ROW_BITS - COL_BITS;

	localparam logic [IDX_W-1:0] REG_WIDTH   = 3'd0;
	localparam logic [IDX_W-1:0] REG_HEIGHT  = 3'd1;
	localparam logic [IDX_W-1:0] REG_KERNEL0 = 3'd2;

	localparam logic ACT_PUSH  = 1'b0;
	localparam logic ACT_FLUSH = 1'b1;

	typedef struct packed {
		logic accept;
		logic tap_start;
		logic tap_step;
		logic div_start;
		logic out_load;
	} ncv_cmd_t;

	typedef struct packed {
		logic emit_now;
		logic tap_last;
		logic mac_busy;
		logic div_done;
		logic out_free;
	} ncv_stat_t;
endpackage
`default_nettype wire

// File: design/ncv_ram.sv
// generic simple dual-port ram with registered read
`timescale 1ns / 1ps
`default_nettype none
module ncv_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end
endmodule
`default_nettype wire

// File: design/ncv_div.sv
// bit-serial signed divider, truncating toward zero, bypass on zero divisor
`timescale 1ns / 1ps
`default_nettype none
module ncv_div #(
	parameter int DVD_W = 26,
	parameter int DSR_W = 17
) (
	input  wire logic                    clk,
	input  wire logic                    arst_n,
	input  wire logic                    start,
	input  wire logic signed [DVD_W-1:0] dvd,
	input  wire logic signed [DSR_W-1:0] dsr,
	output logic                         done,
	output logic signed      [DVD_W-1:0] quo
);
	localparam int CNT_W = $clog2(DVD_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CNT_W-1:0] cnt_q;
	logic [DVD_W-1:0] q_q;
	logic [DSR_W-1:0] rem_q;
	logic [DSR_W-1:0] dsr_q;
	logic             neg_q;
	logic             bypass_q;
	logic [DVD_W-1:0] raw_q;
	logic [DSR_W-1:0] trial;
	logic             fit;

	always_comb begin
		trial = {rem_q[DSR_W-2:0], q_q[DVD_W-1]};
		fit   = (trial >= dsr_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				if (dsr == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end else begin
					busy_q <= 1'b1;
					cnt_q  <= CNT_W'(DVD_W);
				end
			end else if (busy_q) begin
				cnt_q <= cnt_q - CNT_W'(1);
				if (cnt_q == CNT_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			bypass_q <= (dsr == '0);
			raw_q    <= dvd;
			q_q      <= dvd[DVD_W-1] ? DVD_W'(-dvd) : DVD_W'(dvd);
			dsr_q    <= dsr[DSR_W-1] ? DSR_W'(-dsr) : DSR_W'(dsr);
			rem_q    <= '0;
			neg_q    <= dvd[DVD_W-1] ^ dsr[DSR_W-1];
		end else if (busy_q) begin
			q_q   <= {q_q[DVD_W-2:0], fit};
			rem_q <= fit ? (trial - dsr_q) : trial;
		end
	end

	assign done = done_q;
	assign quo  = bypass_q ? $signed(raw_q) : (neg_q ? -$signed(q_q) : $signed(q_q));
endmodule
`default_nettype wire

// File: design/ncv_ctrl.sv
// controller state machine: accept, tap sweep, drain, divide, output load
`timescale 1ns / 1ps
`default_nettype none
module ncv_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              s_tvalid,
	output logic                   s_tready,
	input  wire ncv_pkg::ncv_stat_t st,
	output ncv_pkg::ncv_cmd_t      cmd
);
	localparam logic [2:0] ST_IDLE  = 3'd0;
	localparam logic [2:0] ST_START = 3'd1;
	localparam logic [2:0] ST_TAPS  = 3'd2;
	localparam logic [2:0] ST_DRAIN = 3'd3;
	localparam logic [2:0] ST_DIV   = 3'd4;
	localparam logic [2:0] ST_LOAD  = 3'd5;

	logic [2:0] state_q;
	logic [2:0] state_nxt;

	always_comb begin
		cmd       = '0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				cmd.accept = s_tvalid;
				if (s_tvalid && st.emit_now) begin
					state_nxt = ST_START;
				end
			end
			ST_START: begin
				cmd.tap_start = 1'b1;
				state_nxt     = ST_TAPS;
			end
			ST_TAPS: begin
				cmd.tap_step = 1'b1;
				if (st.tap_last) begin
					state_nxt = ST_DRAIN;
				end
			end
			ST_DRAIN: begin
				if (!st.mac_busy) begin
					cmd.div_start = 1'b1;
					state_nxt     = ST_DIV;
				end
			end
			ST_DIV: begin
				if (st.div_done) begin
					state_nxt = ST_LOAD;
				end
			end
			ST_LOAD: begin
				if (st.out_free) begin
					cmd.out_load = 1'b1;
					state_nxt    = ST_IDLE;
				end
			end
			default: state_nxt = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

	assign s_tready = (state_q == ST_IDLE);

`ifndef NO_ASSERTIONS
	a_load_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> st.out_free)
		else $error("output loaded while previous word still held");
	a_div_after_mac: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.div_start |-> !st.mac_busy)
		else $error("divide started before accumulation finished");
	a_sweep_follows: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.tap_start |=> cmd.tap_step)
		else $error("tap sweep did not follow its start");
	a_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		st.div_done |-> (state_q == ST_DIV))
		else $error("divider finished outside the divide state");
`endif
endmodule
`default_nettype wire

// File: design/ncv_dp.sv
// datapath: geometry, line store, tap sweep, multiply-accumulate, divider, output register
`timescale 1ns / 1ps
`default_nettype none
module ncv_dp #(
	parameter int KERNEL_SIZE = 5,
	parameter int MAX_WIDTH   = 2048,
	parameter int PIXEL_BITS  = 8,
	parameter int COEF_BITS   = 12
) (
	input  wire logic                              clk,
	input  wire logic                              arst_n,
	input  wire ncv_pkg::ncv_cmd_t                 cmd,
	output ncv_pkg::ncv_stat_t                     st,
	input  wire logic [ncv_pkg::IN_DATA_W-1:0]     s_tdata,
	input  wire logic                              s_tuser,
	output logic                                   m_tvalid,
	input  wire logic                              m_tready,
	output logic      [ncv_pkg::OUT_DATA_W-1:0]    m_tdata,
	output logic                                   m_tlast,
	input  wire logic                              cfg_wr_en,
	input  wire logic [ncv_pkg::IDX_W-1:0]         cfg_index,
	input  wire logic [ncv_pkg::CFG_W-1:0]         cfg_data
);
	localparam int HALF      = KERNEL_SIZE / 2;
	localparam int CW        = $clog2(MAX_WIDTH);
	localparam int WW        = CW + 1;
	localparam int SW        = (KERNEL_SIZE > 1) ? $clog2(KERNEL_SIZE) : 1;
	localparam int SLOTS     = 2 * KERNEL_SIZE;
	localparam int SLW       = $clog2(SLOTS);
	localparam int RAM_DEPTH = SLOTS * (2 ** CW);
	localparam int ADDR_W    = $clog2(RAM_DEPTH);
	localparam int LAG_W     = $clog2(HALF * MAX_WIDTH + HALF + 2);
	localparam int PROD_W    = PIXEL_BITS + COEF_BITS + 1;
	localparam int ACC_W     = PROD_W + $clog2(KERNEL_SIZE * KERNEL_SIZE);
	localparam int RS_W      = COEF_BITS + $clog2(KERNEL_SIZE);
	localparam int WGT_W     = COEF_BITS + $clog2(KERNEL_SIZE * KERNEL_SIZE);
	localparam int ROW_W     = KERNEL_SIZE * COEF_BITS;
	localparam int RB        = ncv_pkg::ROW_BITS;
	localparam int TR_W      = RB + 2;
	localparam int TC_W      = CW + 2;
	localparam int WX_W      = ncv_pkg::WIDTH_BITS + 1;

	// configuration
	logic [ncv_pkg::WIDTH_BITS-1:0] width_q;
	logic [RB-1:0]                  height_q;
	logic [ROW_W-1:0]               kern_q [KERNEL_SIZE];
	logic signed [RS_W-1:0]         rsum_q [KERNEL_SIZE];
	logic signed [RS_W-1:0]         rsum_new;
	logic signed [WGT_W-1:0]        weight;
	logic                           geom_wr;

	// geometry and positions
	logic [WX_W-1:0]  wx;
	logic [WW-1:0]    eff_w;
	logic [RB-1:0]    eff_h;
	logic [LAG_W-1:0] lag;
	logic [CW-1:0]    in_col_q;
	logic [RB-1:0]    in_row_q;
	logic [SLW-1:0]   in_slot_q;
	logic [LAG_W-1:0] fill_q;
	logic [CW-1:0]    emit_col_q;
	logic [RB-1:0]    emit_row_q;
	logic [SLW-1:0]   emit_slot_q;
	logic             in_done;
	logic             push;
	logic             last;
	logic             restart;

	// tap sweep
	logic [SW-1:0]          ti_q;
	logic [SW-1:0]          tj_q;
	logic signed [TR_W-1:0] tr_q;
	logic signed [TC_W-1:0] tc_q;
	logic [SLW-1:0]         tslot_q;
	logic [TC_W-1:0]        tc_start;
	logic [SLW:0]           slot_sum;
	logic [SLW-1:0]         slot_start;
	logic                   tap_ok;
	logic [ROW_W-1:0]       krow;
	logic [COEF_BITS-1:0]   coef;

	// line store
	logic [PIXEL_BITS+ncv_pkg::IN_DATA_W-1:0] pix_ext;
	logic [SLW+CW-1:0]      waddr_full;
	logic [SLW+CW-1:0]      raddr_full;
	logic [PIXEL_BITS-1:0]  rdata;

	// mac pipeline
	logic                     en_s1;
	logic                     mask_s1;
	logic [COEF_BITS-1:0]     coef_s1;
	logic                     en_s2;
	logic signed [PROD_W-1:0] prod_s2;
	logic signed [ACC_W-1:0]  acc_q;

	// divider and output
	logic                                      div_done;
	logic signed [ACC_W-1:0]                   quo;
	logic signed [ACC_W+ncv_pkg::OUT_BITS-1:0] quo_ext;
	logic [CW+ncv_pkg::COL_BITS-1:0]           col_ext;
	logic                                      m_tvalid_q;
	logic [ncv_pkg::OUT_BITS-1:0]              filt_q;
	logic [RB-1:0]                             orow_q;
	logic [ncv_pkg::COL_BITS-1:0]              ocol_q;
	logic                                      olast_q;

	always_comb begin
		wx = {1'b0, width_q};
		if (wx == '0) begin
			eff_w = WW'(1);
		end else if (wx > WX_W'(MAX_WIDTH)) begin
			eff_w = WW'(MAX_WIDTH);
		end else begin
			eff_w = WW'(wx);
		end
		eff_h   = (height_q == '0) ? RB'(1) : height_q;
		lag     = LAG_W'(HALF) * LAG_W'(eff_w) + LAG_W'(HALF);
		in_done = (in_row_q == eff_h);
		push    = cmd.accept && (s_tuser == ncv_pkg::ACT_PUSH) && !in_done;
		last    = (emit_row_q == eff_h - RB'(1)) && (WW'(emit_col_q) == eff_w - WW'(1));
		geom_wr = cfg_wr_en && ((cfg_index == ncv_pkg::REG_WIDTH) ||
			(cfg_index == ncv_pkg::REG_HEIGHT));
		restart = geom_wr || (cmd.out_load && last);
	end

	always_comb begin
		rsum_new = '0;
		for (int j = 0; j < KERNEL_SIZE; j++) begin
			rsum_new = rsum_new + RS_W'($signed(cfg_data[j*COEF_BITS +: COEF_BITS]));
		end
		weight = '0;
		for (int k = 0; k < KERNEL_SIZE; k++) begin
			weight = weight + WGT_W'(rsum_q[k]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			width_q  <= ncv_pkg::WIDTH_BITS'(640);
			height_q <= RB'(480);
			for (int k = 0; k < KERNEL_SIZE; k++) begin
				kern_q[k] <= '0;
				rsum_q[k] <= '0;
			end
		end else if (cfg_wr_en) begin
			if (cfg_index == ncv_pkg::REG_WIDTH) begin
				width_q <= cfg_data[ncv_pkg::WIDTH_BITS-1:0];
			end
			if (cfg_index == ncv_pkg::REG_HEIGHT) begin
				height_q <= cfg_data[RB-1:0];
			end
			for (int k = 0; k < KERNEL_SIZE; k++) begin
				if (cfg_index == ncv_pkg::REG_KERNEL0 + ncv_pkg::IDX_W'(k)) begin
					kern_q[k] <= cfg_data[ROW_W-1:0];
					rsum_q[k] <= rsum_new;
				end
			end
		end
	end

	// input and output positions
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			fill_q      <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
		end else if (restart) begin
			in_col_q    <= '0;
			in_row_q    <= '0;
			in_slot_q   <= '0;
			fill_q      <= '0;
			emit_col_q  <= '0;
			emit_row_q  <= '0;
			emit_slot_q <= '0;
		end else begin
			if (push) begin
				if (fill_q != lag) begin
					fill_q <= fill_q + LAG_W'(1);
				end
				if (WW'(in_col_q) + WW'(1) == eff_w) begin
					in_col_q  <= '0;
					in_row_q  <= in_row_q + RB'(1);
					in_slot_q <= (in_slot_q == SLW'(SLOTS - 1)) ? '0 :
						in_slot_q + SLW'(1);
				end else begin
					in_col_q <= in_col_q + CW'(1);
				end
			end
			if (cmd.out_load) begin
				if (WW'(emit_col_q) + WW'(1) == eff_w) begin
					emit_col_q  <= '0;
					emit_row_q  <= emit_row_q + RB'(1);
					emit_slot_q <= (emit_slot_q == SLW'(SLOTS - 1)) ? '0 :
						emit_slot_q + SLW'(1);
				end else begin
					emit_col_q <= emit_col_q + CW'(1);
				end
			end
		end
	end

	// window taps, one per cycle
	always_comb begin
		tc_start = TC_W'(emit_col_q) + TC_W'(HALF);
		slot_sum = (SLW+1)'(emit_slot_q) + (SLW+1)'(HALF);
		if (slot_sum >= (SLW+1)'(SLOTS)) begin
			slot_start = SLW'(slot_sum - (SLW+1)'(SLOTS));
		end else begin
			slot_start = SLW'(slot_sum);
		end
		tap_ok = !tr_q[TR_W-1] && (tr_q[TR_W-2:0] < (TR_W-1)'(eff_h)) &&
			!tc_q[TC_W-1] && (tc_q[TC_W-2:0] < (TC_W-1)'(eff_w));
		krow = kern_q[ti_q];
		coef = krow[tj_q*COEF_BITS +: COEF_BITS];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ti_q    <= '0;
			tj_q    <= '0;
			tr_q    <= '0;
			tc_q    <= '0;
			tslot_q <= '0;
		end else if (cmd.tap_start) begin
			ti_q    <= '0;
			tj_q    <= '0;
			tr_q    <= $signed(TR_W'(emit_row_q) + TR_W'(HALF));
			tc_q    <= $signed(tc_start);
			tslot_q <= slot_start;
		end else if (cmd.tap_step) begin
			if (tj_q == SW'(KERNEL_SIZE - 1)) begin
				tj_q    <= '0;
				ti_q    <= ti_q + SW'(1);
				tc_q    <= $signed(tc_start);
				tr_q    <= tr_q - TR_W'(1);
				tslot_q <= (tslot_q == '0) ? SLW'(SLOTS - 1) : tslot_q - SLW'(1);
			end else begin
				tj_q <= tj_q + SW'(1);
				tc_q <= tc_q - TC_W'(1);
			end
		end
	end

	assign pix_ext    = (PIXEL_BITS + ncv_pkg::IN_DATA_W)'(s_tdata);
	assign waddr_full = {in_slot_q, in_col_q};
	assign raddr_full = {tslot_q, tc_q[CW-1:0]};

	ncv_ram #(
		.WIDTH (PIXEL_BITS),
		.DEPTH (RAM_DEPTH)
	) u_line_store (
		.clk   (clk),
		.we    (push),
		.waddr (waddr_full[ADDR_W-1:0]),
		.wdata (pix_ext[PIXEL_BITS-1:0]),
		.raddr (raddr_full[ADDR_W-1:0]),
		.rdata (rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			en_s1 <= 1'b0;
			en_s2 <= 1'b0;
		end else begin
			en_s1 <= cmd.tap_step;
			en_s2 <= en_s1;
		end
	end

	always_ff @(posedge clk) begin
		mask_s1 <= tap_ok;
		coef_s1 <= coef;
		prod_s2 <= $signed(coef_s1) * $signed({1'b0, mask_s1 ? rdata : '0});
		if (cmd.tap_start) begin
			acc_q <= '0;
		end else if (en_s2) begin
			acc_q <= acc_q + ACC_W'(prod_s2);
		end
	end

	ncv_div #(
		.DVD_W (ACC_W),
		.DSR_W (WGT_W)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.dvd    (acc_q),
		.dsr    (weight),
		.done   (div_done),
		.quo    (quo)
	);

	assign quo_ext = (ACC_W + ncv_pkg::OUT_BITS)'(quo);
	assign col_ext = (CW + ncv_pkg::COL_BITS)'(emit_col_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (cmd.out_load) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			filt_q  <= quo_ext[ncv_pkg::OUT_BITS-1:0];
			orow_q  <= emit_row_q;
			ocol_q  <= col_ext[ncv_pkg::COL_BITS-1:0];
			olast_q <= last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {{ncv_pkg::OUT_PAD{1'b0}}, ocol_q, orow_q, filt_q};
	assign m_tlast  = olast_q;

	always_comb begin
		st.emit_now = (s_tuser == ncv_pkg::ACT_FLUSH) ? in_done :
			(!in_done && (fill_q == lag));
		st.tap_last = (ti_q == SW'(KERNEL_SIZE - 1)) && (tj_q == SW'(KERNEL_SIZE - 1));
		st.mac_busy = en_s1 || en_s2;
		st.div_done = div_done;
		st.out_free = !m_tvalid_q || m_tready;
	end
endmodule
`default_nettype wire

// File: design/normalized_2d_convolution_core.sv
// top level of the normalized 2-d convolution core
//
// channel   direction  signals                          contents
// s_*       in         s_tvalid s_tready s_tdata s_tuser pixel word, tuser = action
// m_*       out        m_tvalid m_tready m_tdata m_tlast filtered, row, column; tlast = last
// cfg_*     in         cfg_wr_en cfg_index cfg_data      register writes, no read-back
//
// a word that yields no output is accepted in idle and leaves the controller there
// a word that yields an output runs the tap start, tap sweep, drain, divide and load states,
// with the divider bypassed when the kernel sum is zero:
// one line-store read per tap, then a one-bit-per-cycle divider
// no clearing pass after reset: the line store is read only where this image wrote it
// a finished output waits in the output register while m_tready is low
`timescale 1ns / 1ps
`default_nettype none
module normalized_2d_convolution_core #(
	parameter int KERNEL_SIZE = 5,
	parameter int MAX_WIDTH   = 2048,
	parameter int PIXEL_BITS  = 8,
	parameter int COEF_BITS   = 12
) (
	input  wire logic                           clk,
	input  wire logic                           arst_n,
	input  wire logic                           s_tvalid,
	output logic                                s_tready,
	input  wire logic [ncv_pkg::IN_DATA_W-1:0]  s_tdata,   // pixel
	input  wire logic                           s_tuser,   // action
	output logic                                m_tvalid,
	input  wire logic                           m_tready,
	output logic      [ncv_pkg::OUT_DATA_W-1:0] m_tdata,   // filtered, out_row, out_col, pad
	output logic                                m_tlast,
	input  wire logic                           cfg_wr_en,
	input  wire logic [ncv_pkg::IDX_W-1:0]      cfg_index,
	input  wire logic [ncv_pkg::CFG_W-1:0]      cfg_data
);
	ncv_pkg::ncv_cmd_t  cmd;
	ncv_pkg::ncv_stat_t st;

	ncv_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.st       (st),
		.cmd      (cmd)
	);

	ncv_dp #(
		.KERNEL_SIZE (KERNEL_SIZE),
		.MAX_WIDTH   (MAX_WIDTH),
		.PIXEL_BITS  (PIXEL_BITS),
		.COEF_BITS   (COEF_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tlast   (m_tlast),
		.cfg_wr_en (cfg_wr_en),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);
endmodule
`default_nettype wire

// File: tb/sv/tb.sv
// self-checking testbench for the normalized 2-d convolution core
`timescale 1ns / 1ps
module tb;
	import ncv_pkg::*;

	localparam int KSZ      = 5;
	localparam int HALF     = KSZ / 2;
	localparam int MAXW     = 2048;
	localparam int SLOTS    = 2 * KSZ;
	localparam int N_ITEMS  = 1950;
	localparam int QUIET_LIM = 20000;
	localparam int HOLD_CYC = 1500;
	localparam int SETTLE   = 100;

	typedef struct packed {
		logic [OUT_BITS-1:0] filtered;
		logic [ROW_BITS-1:0] row;
		logic [COL_BITS-1:0] col;
		logic                last;
	} pix_out_t;

	typedef struct {
		logic                act;
		logic [7:0]          pix;
		bit                  reconf;
		bit                  typed;
		pix_out_t            res;
	} dir_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	logic [IN_DATA_W-1:0] s_tdata = '0;   // pixel
	logic s_tuser = 1'b0;                 // action
	logic m_tvalid;
	logic m_tready = 1'b0;
	logic [OUT_DATA_W-1:0] m_tdata;       // filtered, out_row, out_col, pad
	logic m_tlast;
	logic cfg_wr_en = 1'b0;
	logic [IDX_W-1:0] cfg_index = '0;
	logic [CFG_W-1:0] cfg_data = '0;

	normalized_2d_convolution_core u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tlast(m_tlast),
		.cfg_wr_en(cfg_wr_en), .cfg_index(cfg_index), .cfg_data(cfg_data)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// mirrored core state
	logic [WIDTH_BITS-1:0] img_w;
	logic [ROW_BITS-1:0]   img_h;
	logic [CFG_W-1:0]      kern [KSZ];
	logic [7:0]            lines [SLOTS][MAXW];
	int unsigned in_r, in_c, out_r, out_c, n_in, n_out;
	longint weight;

	pix_out_t pending_q [$];
	int errors = 0;
	int mode = 0;
	bit hold_req = 0;
	int hold_cnt = 0;
	int quiet = 0;

	function automatic int unsigned eff_w();
		if (img_w == 0) return 1;
		if (img_w > MAXW) return MAXW;
		return img_w;
	endfunction

	function automatic int unsigned eff_h();
		return (img_h == 0) ? 1 : img_h;
	endfunction

	function automatic longint coef(int i, int j);
		logic signed [11:0] c;
		c = kern[i][j*12 +: 12];
		return c;
	endfunction

	function automatic void restart_img();
		in_r = 0; in_c = 0; out_r = 0; out_c = 0; n_in = 0; n_out = 0;
	endfunction

	function automatic void model_cfg(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		if (idx == REG_WIDTH) begin
			img_w = val[WIDTH_BITS-1:0];
			restart_img();
		end else if (idx == REG_HEIGHT) begin
			img_h = val[ROW_BITS-1:0];
			restart_img();
		end else if (idx >= REG_KERNEL0 && idx <= REG_KERNEL0 + KSZ - 1) begin
			kern[idx - REG_KERNEL0] = val;
			weight = 0;
			for (int i = 0; i < KSZ; i++)
				for (int j = 0; j < KSZ; j++)
					weight += coef(i, j);
		end
	endfunction

	function automatic pix_out_t window_sum();
		int unsigned w, h;
		longint acc, rr, cc;
		pix_out_t o;
		w = eff_w();
		h = eff_h();
		acc = 0;
		for (int i = 0; i < KSZ; i++) begin
			rr = longint'(out_r) + HALF - i;
			if (rr < 0 || rr >= h) continue;
			for (int j = 0; j < KSZ; j++) begin
				cc = longint'(out_c) + HALF - j;
				if (cc < 0 || cc >= w) continue;
				acc += coef(i, j) * longint'(lines[rr % SLOTS][cc]);
			end
		end
		if (weight != 0) acc = acc / weight;
		o.filtered = acc[OUT_BITS-1:0];
		o.row = out_r[ROW_BITS-1:0];
		o.col = out_c[COL_BITS-1:0];
		o.last = (out_r == h - 1) && (out_c == w - 1);
		n_out++;
		out_c++;
		if (out_c >= w) begin
			out_c = 0;
			out_r++;
		end
		if (o.last) restart_img();
		return o;
	endfunction

	// returns 1 when the word changed state; got marks a produced output
	function automatic bit conv_step(logic act, logic [7:0] pix, output bit got,
			output pix_out_t o);
		int unsigned w, h, total, lag;
		w = eff_w();
		h = eff_h();
		total = w * h;
		lag = HALF * w + HALF;
		got = 0;
		o = '0;
		if (act == ACT_FLUSH) begin
			if (n_in >= total && n_out < total) begin
				o = window_sum();
				got = 1;
			end
			return got;
		end
		if (n_in >= total) return 0;
		lines[in_r % SLOTS][in_c % MAXW] = pix;
		n_in++;
		in_c++;
		if (in_c >= w) begin
			in_c = 0;
			in_r++;
		end
		if (n_in > lag && n_out < total) begin
			o = window_sum();
			got = 1;
		end
		return 1;
	endfunction

	task automatic cfg_write(logic [IDX_W-1:0] idx, logic [CFG_W-1:0] val);
		cfg_wr_en <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		@(posedge clk);
		cfg_wr_en <= 1'b0;
		model_cfg(idx, val);
		@(posedge clk);
	endtask

	task automatic wait_idle();
		while (pending_q.size() != 0) @(posedge clk);
		repeat (SETTLE) @(posedge clk);
	endtask

	task automatic send_word(logic act, logic [7:0] pix, bit typed, pix_out_t typed_res,
			output bit live);
		int idle_pct;
		bit got;
		pix_out_t o;
		idle_pct = (mode == 0) ? 14 : (mode == 1) ? 46 : 0;
		while ($urandom_range(0, 99) < idle_pct) begin
			s_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser <= act;
		s_tdata <= pix;
		do @(posedge clk); while (!s_tready);
		live = conv_step(act, pix, got, o);
		if (got) pending_q.insert(pending_q.size(), typed ? typed_res : o);
	endtask

	task automatic load_kernel(int kind);
		logic [CFG_W-1:0] rows [KSZ];
		logic signed [11:0] c;
		int sum;
		sum = 0;
		for (int i = 0; i < KSZ; i++) begin
			for (int j = 0; j < KSZ; j++) begin
				case (kind)
					0: c = $urandom_range(0, 4095);
					1: c = $urandom_range(0, 3);
					2: c = $urandom_range(0, 1) ? 12'sd2047 : -12'sd2048;
					default: c = $signed($urandom_range(0, 6)) - 3;
				endcase
				if (!(i == HALF && j == HALF)) sum += c;
				rows[i][j*12 +: 12] = c;
			end
		end
		if (kind == 3) rows[HALF][HALF*12 +: 12] = -sum;
		for (int i = 0; i < KSZ; i++) cfg_write(REG_KERNEL0 + i, rows[i]);
	endtask

	always @(posedge clk) begin
		pix_out_t e, a;
		int idle_pct;
		if (m_tvalid && m_tready) begin
			a.filtered = m_tdata[OUT_BITS-1:0];
			a.row = m_tdata[OUT_BITS +: ROW_BITS];
			a.col = m_tdata[OUT_BITS+ROW_BITS +: COL_BITS];
			a.last = m_tlast;
			if (pending_q.size() == 0) begin
				$display("%0t unexpected word row %0d col %0d", $time, a.row, a.col);
				errors++;
			end else begin
				e = pending_q.pop_front();
				if (a.filtered !== e.filtered) begin
					$display("%0t filtered expected %0d got %0d", $time,
						$signed(e.filtered), $signed(a.filtered));
					errors++;
				end
				if (a.row !== e.row) begin
					$display("%0t out_row expected %0d got %0d", $time, e.row, a.row);
					errors++;
				end
				if (a.col !== e.col) begin
					$display("%0t out_col expected %0d got %0d", $time, e.col, a.col);
					errors++;
				end
				if (a.last !== e.last) begin
					$display("%0t last expected %0d got %0d", $time, e.last, a.last);
					errors++;
				end
			end
		end
		idle_pct = (mode == 0) ? 46 : (mode == 1) ? 14 : 0;
		if (hold_req && hold_cnt == 0) hold_cnt = HOLD_CYC;
		if (hold_cnt > 0) begin
			hold_cnt--;
			if (hold_cnt == 0) hold_req = 0;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= idle_pct);
		end
	end

	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_wr_en)
			quiet <= 0;
		else
			quiet <= quiet + 1;
		if (quiet >= QUIET_LIM) begin
			$display("Mismatches found");
			$finish;
		end
	end

	initial begin
		dir_row_t dir_tab [17];
		int unsigned w, h, total, n_push;
		int count;
		bit live, broken, held;
		pix_out_t none;
		none = '0;
		held = 0;
		img_w = 640;
		img_h = 480;
		weight = 0;
		for (int i = 0; i < KSZ; i++) kern[i] = '0;
		for (int i = 0; i < SLOTS; i++)
			for (int j = 0; j < MAXW; j++) lines[i][j] = '0;
		restart_img();

		// 1x1 image with zero kernel, then 3x2 image with identity kernel
		dir_tab = '{
			'{ACT_FLUSH, 8'd0,   0, 0, '0},
			'{ACT_PUSH,  8'd255, 0, 0, '0},
			'{ACT_PUSH,  8'd7,   0, 0, '0},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd0, 16'd0, 11'd0, 1'b1}},
			'{ACT_FLUSH, 8'd0,   0, 0, '0},
			'{ACT_PUSH,  8'd0,   1, 0, '0},
			'{ACT_PUSH,  8'd255, 0, 0, '0},
			'{ACT_PUSH,  8'd1,   0, 0, '0},
			'{ACT_PUSH,  8'd128, 0, 0, '0},
			'{ACT_PUSH,  8'd64,  0, 0, '0},
			'{ACT_PUSH,  8'd200, 0, 0, '0},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd0,   16'd0, 11'd0, 1'b0}},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd255, 16'd0, 11'd1, 1'b0}},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd1,   16'd0, 11'd2, 1'b0}},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd128, 16'd1, 11'd0, 1'b0}},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd64,  16'd1, 11'd1, 1'b0}},
			'{ACT_FLUSH, 8'd0,   0, 1, '{25'd200, 16'd1, 11'd2, 1'b1}}
		};

		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		cfg_write(REG_WIDTH, 60'd0);
		cfg_write(REG_HEIGHT, 60'd0);
		foreach (dir_tab[k]) begin
			if (dir_tab[k].reconf) begin
				s_tvalid <= 1'b0;
				wait_idle();
				cfg_write(REG_WIDTH, 60'd3);
				cfg_write(REG_HEIGHT, 60'd2);
				cfg_write(REG_KERNEL0 + 2, 60'd1 << 24);
			end
			send_word(dir_tab[k].act, dir_tab[k].pix, dir_tab[k].typed, dir_tab[k].res, live);
		end
		s_tvalid <= 1'b0;
		wait_idle();

		// widest row and tallest image, abandoned after a few pixels
		cfg_write(REG_WIDTH, 60'd4095);
		cfg_write(REG_HEIGHT, 60'd65535);
		load_kernel(2);
		for (int k = 0; k < 20; k++) send_word(ACT_PUSH, $urandom_range(0, 255), 0, none, live);
		s_tvalid <= 1'b0;
		wait_idle();

		count = 0;
		while (count < N_ITEMS) begin
			mode = (count < N_ITEMS / 3) ? 0 : (count < 2 * N_ITEMS / 3) ? 1 : 2;
			w = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
			h = $urandom_range(1, 6);
			if ($urandom_range(0, 19) == 0) w = 0;
			if ($urandom_range(0, 19) == 0) h = 0;
			cfg_write(REG_WIDTH, w);
			cfg_write(REG_HEIGHT, h);
			load_kernel($urandom_range(0, 3));
			total = eff_w() * eff_h();
			broken = ($urandom_range(0, 7) == 0);
			n_push = broken ? $urandom_range(0, total) : total;
			if (!held && count > N_ITEMS / 5) begin
				hold_req = 1;
				held = 1;
			end
			for (int unsigned k = 0; k < n_push; k++) begin
				if ($urandom_range(0, 9) == 0) send_word(ACT_FLUSH, $urandom_range(0, 255), 0, none, live);
				send_word(ACT_PUSH, $urandom_range(0, 255), 0, none, live);
				if (live) count++;
			end
			if (!broken) begin
				if ($urandom_range(0, 3) == 0) send_word(ACT_PUSH, $urandom_range(0, 255), 0, none, live);
				while (n_in >= total) begin
					send_word(ACT_FLUSH, $urandom_range(0, 255), 0, none, live);
					count++;
				end
				if ($urandom_range(0, 3) == 0) send_word(ACT_FLUSH, 8'd0, 0, none, live);
			end
			s_tvalid <= 1'b0;
			wait_idle();
		end

		repeat (SETTLE) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0) begin
			$display("No mismatches found");
		end else begin
			$display("Mismatches found");
		end
		$finish;
	end
endmodule
